### sv/wca_pkg.sv
// ----------------------------------------------------------------------------
// wca_pkg: shared definitions for the weighted centroid accumulator
// Field widths, weight mode codes and the divider status struct.
// ----------------------------------------------------------------------------
package wca_pkg;

  localparam int POS_W   = 32;
  localparam int WGT_W   = 24;
  localparam int SUMW_W  = 32;
  localparam int ACC_W   = 64;
  localparam int PROD_W  = WGT_W + 1 + POS_W;
  localparam int NCOORD  = 3;
  localparam int K_W     = $clog2(NCOORD);
  localparam int DIV_STEPS = ACC_W;
  localparam int DCNT_W  = $clog2(DIV_STEPS);

  localparam logic [WGT_W-1:0] UNIT_WEIGHT = WGT_W'(4096);

  localparam logic [1:0] MODE_UNIT   = 2'd0;
  localparam logic [1:0] MODE_MASS   = 2'd1;
  localparam logic [1:0] MODE_CHARGE = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### sv/weighted_centroid_accumulator_top.sv
// An unselected atom that is not last is simply accepted; a selected atom is
// accepted, then gets one multiply and one saturating add per axis on the
// shared multiplier and adder. A last atom then takes one division per axis in
// the shared bit-serial divider, or none when the total weight is zero, and
// the result loads the output register once it is free. Reset clears the sums
// and flags and sets the weight mode to atom mass.
// ----------------------------------------------------------------------------
// weighted_centroid_accumulator_top: weighted center of mass of an atom set
// Accumulates weight and weight times position for selected atoms and, on the
// last atom, divides the sums by the total weight.
// ----------------------------------------------------------------------------
module weighted_centroid_accumulator_top (
  input  logic         clk,
  input  logic         rst,
  // Configuration: weight mode.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data,
  // Atom stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], atom_mass[119:96],
  //        atom_charge[143:120]
  input  logic [143:0] s_axis_tdata,
  // tuser: selected[0]
  input  logic         s_axis_tuser,
  // tlast: last_atom
  input  logic         s_axis_tlast,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: center_x[31:0], center_y[63:32], center_z[95:64],
  //        total_weight[127:96]
  output logic [127:0] m_axis_tdata,
  // tuser: zero_weight[0], overflowed[1]
  output logic [1:0]   m_axis_tuser
);

  localparam int POS_W  = wca_pkg::POS_W;
  localparam int WGT_W  = wca_pkg::WGT_W;
  localparam int SUMW_W = wca_pkg::SUMW_W;
  localparam int ACC_W  = wca_pkg::ACC_W;
  localparam int PROD_W = wca_pkg::PROD_W;
  localparam int K_W    = wca_pkg::K_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_ADD   = 6'b000100,
    S_DIVGO = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t                     state;
  logic [1:0]                 weight_mode;
  logic [K_W-1:0]             k;
  logic signed [POS_W-1:0]    pos [wca_pkg::NCOORD];
  logic [WGT_W-1:0]           wgt;
  logic                       last;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    sum [wca_pkg::NCOORD];
  logic [SUMW_W-1:0]          sum_weight;
  logic                       saturated_seen;
  logic [POS_W-1:0]           center [wca_pkg::NCOORD];
  logic                       zero_wt;

  logic                       in_xfer;
  logic [WGT_W-1:0]           in_mass;
  logic [WGT_W-1:0]           in_charge;
  logic [WGT_W-1:0]           in_abs_charge;
  logic [WGT_W-1:0]           in_wgt;
  logic signed [PROD_W-1:0]   prod_c;
  logic signed [ACC_W:0]      acc_sum;
  logic                       acc_ovf;
  logic [SUMW_W:0]            wsum;
  logic                       sum_neg;
  logic [ACC_W-1:0]           sum_mag;
  logic                       div_start;
  wca_pkg::div_stat_t         div_stat;
  logic [ACC_W-1:0]           div_q;
  logic [POS_W-1:0]           q_clamped;
  logic                       out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign in_mass       = s_axis_tdata[119:96];
  assign in_charge     = s_axis_tdata[143:120];
  // The magnitude of the most negative charge still fits as an unsigned value.
  assign in_abs_charge = in_charge[WGT_W-1] ? (~in_charge + 1'b1) : in_charge;

  always_comb begin
    case (weight_mode)
      wca_pkg::MODE_MASS:   in_wgt = in_mass;
      wca_pkg::MODE_CHARGE: in_wgt = in_abs_charge;
      default:              in_wgt = wca_pkg::UNIT_WEIGHT;
    endcase
  end

  // Shared multiplier and saturating adder, one axis at a time.
  assign prod_c  = $signed({1'b0, wgt}) * pos[k];
  assign acc_sum = {sum[k][ACC_W-1], sum[k]} +
                   {{(ACC_W + 1 - PROD_W){prod[PROD_W-1]}}, prod};
  assign acc_ovf = acc_sum[ACC_W] ^ acc_sum[ACC_W-1];
  assign wsum    = {1'b0, sum_weight} + {{(SUMW_W + 1 - WGT_W){1'b0}}, wgt};

  assign sum_neg   = sum[k][ACC_W-1];
  assign sum_mag   = sum_neg ? (ACC_W'(0) - sum[k]) : sum[k];
  assign div_start = (state == S_DIVGO) && (sum_weight != '0);

  wca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (sum_weight),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Truncated quotient with sign restored, clamped to the 32-bit range.
  always_comb begin
    if (sum_neg) begin
      if (div_q > ACC_W'(64'h8000_0000)) begin
        q_clamped = 32'h8000_0000;
      end else begin
        q_clamped = POS_W'(ACC_W'(0) - div_q);
      end
    end else begin
      if (div_q > ACC_W'(64'h7FFF_FFFF)) begin
        q_clamped = 32'h7FFF_FFFF;
      end else begin
        q_clamped = div_q[POS_W-1:0];
      end
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      weight_mode    <= wca_pkg::MODE_MASS;
      k              <= '0;
      sum[0]         <= '0;
      sum[1]         <= '0;
      sum[2]         <= '0;
      sum_weight     <= '0;
      saturated_seen <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        weight_mode <= cfg_data;
      end
      // In S_OUT a free output register is reloaded below instead.
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            k <= '0;
            if (s_axis_tuser) begin
              state <= S_MUL;
            end else if (s_axis_tlast) begin
              state <= S_DIVGO;
            end
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          if (acc_ovf) begin
            sum[k] <= acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
          end else begin
            sum[k] <= acc_sum[ACC_W-1:0];
          end
          if (k == '0) begin
            if (wsum[SUMW_W]) begin
              sum_weight <= '1;
            end else begin
              sum_weight <= wsum[SUMW_W-1:0];
            end
          end
          if (acc_ovf || ((k == '0) && wsum[SUMW_W])) begin
            saturated_seen <= 1'b1;
          end
          if (k == K_W'(wca_pkg::NCOORD - 1)) begin
            k     <= '0;
            state <= last ? S_DIVGO : S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_MUL;
          end
        end
        S_DIVGO: begin
          state <= (sum_weight == '0) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (k == K_W'(wca_pkg::NCOORD - 1)) begin
              state <= S_OUT;
            end else begin
              k     <= k + 1'b1;
              state <= S_DIVGO;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid  <= 1'b1;
            sum[0]         <= '0;
            sum[1]         <= '0;
            sum[2]         <= '0;
            sum_weight     <= '0;
            saturated_seen <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pos[0] <= s_axis_tdata[31:0];
      pos[1] <= s_axis_tdata[63:32];
      pos[2] <= s_axis_tdata[95:64];
      wgt    <= in_wgt;
      last   <= s_axis_tlast;
    end
    if (state == S_MUL) begin
      prod <= prod_c;
    end
    if (state == S_DIVGO) begin
      zero_wt <= (sum_weight == '0);
      if (sum_weight == '0) begin
        center[0] <= '0;
        center[1] <= '0;
        center[2] <= '0;
      end
    end
    if (state == S_DIV && div_stat.done) begin
      center[k] <= q_clamped;
    end
    if (state == S_OUT && out_free) begin
      m_axis_tdata <= {sum_weight, center[2], center[1], center[0]};
      m_axis_tuser <= {saturated_seen, zero_wt};
    end
  end

endmodule

### sv/wca_div.sv
// ----------------------------------------------------------------------------
// wca_div: iterative unsigned divider
// Restoring division of a 64-bit dividend by a 32-bit divisor, one quotient
// bit per cycle. Done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module wca_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [wca_pkg::ACC_W-1:0]        dividend,
  input  logic [wca_pkg::SUMW_W-1:0]       divisor,
  output wca_pkg::div_stat_t               stat,
  output logic [wca_pkg::ACC_W-1:0]        quotient
);

  logic                          busy;
  logic                          done;
  logic [wca_pkg::DCNT_W-1:0]    cnt;
  logic [wca_pkg::SUMW_W-1:0]    rem;
  logic [wca_pkg::ACC_W-1:0]     quo;
  logic [wca_pkg::SUMW_W-1:0]    dvsr;

  logic [wca_pkg::SUMW_W:0]      trial;
  logic [wca_pkg::SUMW_W:0]      diff;
  logic                          qbit;

  // The partial remainder stays below the divisor, so the shifted trial
  // value fits in one bit more than the divisor.
  assign trial = {rem, quo[wca_pkg::ACC_W-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign qbit  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == wca_pkg::DCNT_W'(wca_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= qbit ? diff[wca_pkg::SUMW_W-1:0] : trial[wca_pkg::SUMW_W-1:0];
      quo <= {quo[wca_pkg::ACC_W-2:0], qbit};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule
